@@ rtl/pose_frame_deframer_core_defines.svh @@
// assertion macros used by the checker file
`ifndef POSE_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define POSE_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication under reset
`define PFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfd same-cycle check failed");

// next-cycle implication under reset
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfd next-cycle check failed");

`endif

@@ rtl/pfd_pkg.sv @@
package pfd_pkg;

    localparam int unsigned PAYLOAD_BYTES = 24;
    localparam int unsigned IDX_W         = (PAYLOAD_BYTES > 2) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int unsigned WORD_COUNT    = 6;
    localparam int unsigned WORD_BYTES    = 4;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    typedef logic [WORD_COUNT-1:0][31:0] word_arr_t;

    typedef struct packed {
        logic shift_en;
        logic done;
        logic link;
    } parse_ctl_t;

endpackage

@@ rtl/pfd_parser.sv @@
module pfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              overrun,
    output pfd_pkg::parse_ctl_t ctl
);

    typedef enum logic [2:0] {
        HUNT      = 3'd0,
        SEEN_CR   = 3'd1,
        PAYLOAD   = 3'd2,
        EXPECT_LF = 3'd3,
        EXPECT_CR = 3'd4
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [pfd_pkg::IDX_W-1:0] byte_index_reg, byte_index_next;
    logic                      link_reg, link_next;
    logic                      done;
    logic                      shift_en;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        link_next       = link_reg;
        done            = 1'b0;
        shift_en        = 1'b0;
        if (overrun)
        begin
            phase_next = HUNT;
            link_next  = 1'b0;
        end
        else
        begin
            case (phase_reg)
                HUNT:
                begin
                    if (rx_byte == pfd_pkg::BYTE_CR)
                    begin
                        phase_next = SEEN_CR;
                        link_next  = 1'b1;
                    end
                end
                SEEN_CR:
                begin
                    // repeated cr bytes keep waiting for the lf
                    if (rx_byte == pfd_pkg::BYTE_LF)
                    begin
                        byte_index_next = '0;
                        phase_next      = PAYLOAD;
                    end
                    else if (rx_byte != pfd_pkg::BYTE_CR)
                    begin
                        phase_next = HUNT;
                    end
                end
                PAYLOAD:
                begin
                    shift_en = 1'b1;
                    if (byte_index_reg == pfd_pkg::IDX_W'(pfd_pkg::PAYLOAD_BYTES - 1))
                    begin
                        byte_index_next = '0;
                        phase_next      = EXPECT_LF;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + pfd_pkg::IDX_W'(1);
                    end
                end
                EXPECT_LF:
                begin
                    phase_next = (rx_byte == pfd_pkg::BYTE_LF) ? EXPECT_CR : HUNT;
                end
                EXPECT_CR:
                begin
                    done       = (rx_byte == pfd_pkg::BYTE_CR);
                    phase_next = HUNT;
                end
                default:
                begin
                    phase_next = HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= HUNT;
            byte_index_reg <= '0;
            link_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            link_reg       <= link_next;
        end
    end

    assign ctl.shift_en = accept && shift_en;
    assign ctl.done     = done;
    assign ctl.link     = link_next;

endmodule

@@ rtl/pfd_payload.sv @@
module pfd_payload (
    input  logic               clk,
    input  logic               shift_en,
    input  logic [7:0]         rx_byte,
    output pfd_pkg::word_arr_t words
);

    // newest byte at entry 0, so the first payload byte ends at the last entry
    logic [7:0] store_reg [pfd_pkg::PAYLOAD_BYTES];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            store_reg[0] <= rx_byte;
            for (int i = 1; i < int'(pfd_pkg::PAYLOAD_BYTES); i++)
            begin
                store_reg[i] <= store_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < int'(pfd_pkg::WORD_COUNT); k++)
    begin : g_word
        for (genvar b = 0; b < int'(pfd_pkg::WORD_BYTES); b++)
        begin : g_byte
            localparam int POS = k * int'(pfd_pkg::WORD_BYTES) + b;
            if (POS < int'(pfd_pkg::PAYLOAD_BYTES))
            begin : g_tap
                assign words[k][8*b +: 8] = store_reg[int'(pfd_pkg::PAYLOAD_BYTES) - 1 - POS];
            end
            else
            begin : g_pad
                assign words[k][8*b +: 8] = 8'h00;
            end
        end
    end

endmodule

@@ rtl/pose_frame_deframer_core.sv @@
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// byte in   | in_valid / in_ready  | rx_byte, overrun
// result    | out_valid / out_ready| frame_valid, six payload words, link_up
//
// one byte per cycle while in_ready is high; each accepted byte gives one result beat in the cycle after it is accepted
// the parser state and payload shift line update at the input beat, the result
// register holds the beat until taken; a new byte is taken while it is taken
// in_ready drops only while a result waits with out_ready low
// rst_n clears parser phase, byte count, link flag and the result valid
module pose_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        overrun,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_valid,
    output logic [31:0] heading_word,
    output logic [31:0] roll_word,
    output logic [31:0] pitch_word,
    output logic [31:0] pos_x_word,
    output logic [31:0] pos_y_word,
    output logic [31:0] yaw_rate_word,
    output logic        link_up
);

    logic                accept;
    pfd_pkg::parse_ctl_t ctl;
    pfd_pkg::word_arr_t  words;
    logic                out_valid_reg;
    logic                frame_valid_reg;
    logic                link_up_reg;
    pfd_pkg::word_arr_t  words_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .overrun (overrun),
        .ctl     (ctl)
    );

    pfd_payload u_payload (
        .clk      (clk),
        .shift_en (ctl.shift_en),
        .rx_byte  (rx_byte),
        .words    (words)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_valid_reg <= ctl.done;
            link_up_reg     <= ctl.link;
            words_reg       <= ctl.done ? words : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_valid   = frame_valid_reg;
    assign link_up       = link_up_reg;
    assign heading_word  = words_reg[0];
    assign roll_word     = words_reg[1];
    assign pitch_word    = words_reg[2];
    assign pos_x_word    = words_reg[3];
    assign pos_y_word    = words_reg[4];
    assign yaw_rate_word = words_reg[5];

endmodule

@@ rtl/pfd_checker.sv @@
`include "pose_frame_deframer_core_defines.svh"

module pfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  rx_byte,
    input logic        overrun,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_valid,
    input logic [31:0] heading_word,
    input logic [31:0] roll_word,
    input logic [31:0] pitch_word,
    input logic [31:0] pos_x_word,
    input logic [31:0] pos_y_word,
    input logic [31:0] yaw_rate_word,
    input logic        link_up
);

    logic words_zero;
    logic in_beat;
    logic ovr_beat;
    logic no_close;

    assign words_zero = (heading_word == '0) && (roll_word == '0) && (pitch_word == '0)
                     && (pos_x_word == '0) && (pos_y_word == '0) && (yaw_rate_word == '0);
    assign in_beat    = in_valid && in_ready;
    assign ovr_beat   = in_beat && overrun;
    assign no_close   = overrun || (rx_byte != pfd_pkg::BYTE_CR);

    // an overrun beat yields a plain result with the link down
    `PFD_ASSERT_NEXT(a_overrun_link, clk, rst_n, ovr_beat, out_valid && !link_up && !frame_valid)
    // only a clean cr byte can close a frame
    `PFD_ASSERT_NEXT(a_frame_needs_cr, clk, rst_n, in_beat && no_close, !frame_valid)
    // every input beat produces a result beat
    `PFD_ASSERT_NEXT(a_beat_gives_result, clk, rst_n, in_beat, out_valid)
    // a waiting result blocks new bytes
    `PFD_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !in_ready)
    // words are zero unless a frame completes, and a frame needs the link
    `PFD_ASSERT_SAME(a_frame_payload, clk, rst_n, out_valid, frame_valid ? link_up : words_zero)

endmodule

bind pose_frame_deframer_core pfd_checker u_pfd_checker (.*);

@@ bench/pfd_result_checker.sv @@
`timescale 1ns / 100ps

module pfd_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        overrun,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        frame_valid,
    input  logic [31:0] heading_word,
    input  logic [31:0] roll_word,
    input  logic [31:0] pitch_word,
    input  logic [31:0] pos_x_word,
    input  logic [31:0] pos_y_word,
    input  logic [31:0] yaw_rate_word,
    input  logic        link_up,
    input  logic        wrap_up,
    output int          fail_count,
    output int          pending,
    output int          frames_published
);

    typedef enum logic [2:0] {
        HUNT       = 3'd0,
        SAW_CR     = 3'd1,
        IN_PAYLOAD = 3'd2,
        WANT_LF    = 3'd3,
        WANT_CR    = 3'd4
    } parse_phase_t;

    typedef struct packed {
        logic               done;
        pfd_pkg::word_arr_t words;
        logic               link;
    } pose_result_t;

    string word_label [pfd_pkg::WORD_COUNT] = '{"heading_word", "roll_word", "pitch_word",
                                                "pos_x_word", "pos_y_word", "yaw_rate_word"};

    parse_phase_t  parse_phase;
    int unsigned   payload_index;
    logic [7:0]    payload_bytes [pfd_pkg::PAYLOAD_BYTES];
    logic          link_seen;
    pose_result_t  expected_poses [$];
    int            mismatch_count = 0;
    int            queued_count = 0;
    int            frame_count = 0;
    bit            wrapped_up = 1'b0;

    assign fail_count       = mismatch_count;
    assign pending          = queued_count;
    assign frames_published = frame_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("  mismatch at %0t: %s", $time, what);
    endtask

    // advance the frame parser by one byte and return the beat it should produce
    function automatic pose_result_t advance_parser(input logic [7:0] b, input logic ovr);
        pose_result_t r;
        int unsigned  pos;
        r = '0;
        if (ovr)
        begin
            parse_phase = HUNT;
            link_seen   = 1'b0;
        end
        else
        begin
            case (parse_phase)
                HUNT:
                begin
                    if (b == pfd_pkg::BYTE_CR)
                    begin
                        parse_phase = SAW_CR;
                        link_seen   = 1'b1;
                    end
                end
                SAW_CR:
                begin
                    if (b == pfd_pkg::BYTE_LF)
                    begin
                        payload_index = 0;
                        parse_phase   = IN_PAYLOAD;
                    end
                    else if (b != pfd_pkg::BYTE_CR)
                    begin
                        parse_phase = HUNT;
                    end
                end
                IN_PAYLOAD:
                begin
                    if (payload_index < pfd_pkg::PAYLOAD_BYTES)
                        payload_bytes[payload_index] = b;
                    payload_index++;
                    if (payload_index >= pfd_pkg::PAYLOAD_BYTES)
                    begin
                        payload_index = 0;
                        parse_phase   = WANT_LF;
                    end
                end
                WANT_LF:
                begin
                    parse_phase = (b == pfd_pkg::BYTE_LF) ? WANT_CR : HUNT;
                end
                WANT_CR:
                begin
                    r.done      = (b == pfd_pkg::BYTE_CR);
                    parse_phase = HUNT;
                end
                default:
                begin
                    parse_phase = HUNT;
                end
            endcase
        end
        if (r.done)
        begin
            // little-endian words, bytes past the payload read as zero
            for (int k = 0; k < int'(pfd_pkg::WORD_COUNT); k++)
            begin
                for (int j = 0; j < int'(pfd_pkg::WORD_BYTES); j++)
                begin
                    pos = k * pfd_pkg::WORD_BYTES + j;
                    r.words[k][8*j +: 8] = (pos < pfd_pkg::PAYLOAD_BYTES) ? payload_bytes[pos]
                                                                          : 8'h00;
                end
            end
        end
        r.link = link_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_result_t want;
        pose_result_t got;
        if (!rst_n)
        begin
            parse_phase   = HUNT;
            payload_index = 0;
            link_seen     = 1'b0;
            for (int i = 0; i < int'(pfd_pkg::PAYLOAD_BYTES); i++)
                payload_bytes[i] = 8'h00;
            expected_poses.delete();
            queued_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.done     = frame_valid;
                got.words[0] = heading_word;
                got.words[1] = roll_word;
                got.words[2] = pitch_word;
                got.words[3] = pos_x_word;
                got.words[4] = pos_y_word;
                got.words[5] = yaw_rate_word;
                got.link     = link_up;
                if (expected_poses.size() == 0)
                begin
                    report_mismatch("result beat with no byte waiting for it");
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (got.done !== want.done)
                        report_mismatch($sformatf("frame_valid got %b want %b",
                                                  got.done, want.done));
                    for (int k = 0; k < int'(pfd_pkg::WORD_COUNT); k++)
                    begin
                        if (got.words[k] !== want.words[k])
                            report_mismatch($sformatf("%s got %h want %h", word_label[k],
                                                      got.words[k], want.words[k]));
                    end
                    if (got.link !== want.link)
                        report_mismatch($sformatf("link_up got %b want %b",
                                                  got.link, want.link));
                    if (want.done)
                        frame_count++;
                end
            end
            if (in_valid && in_ready)
                expected_poses.push_back(advance_parser(rx_byte, overrun));
            queued_count = expected_poses.size();
            if (wrap_up && !wrapped_up)
            begin
                wrapped_up = 1'b1;
                if (queued_count != 0)
                    report_mismatch($sformatf("%0d result beats never arrived", queued_count));
            end
        end
    end

endmodule

@@ bench/pose_frame_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module pose_frame_deframer_core_tb;

    localparam int ITEM_TARGET  = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;
    localparam int IDLE_PERCENT = 28;
    localparam int PAY_BYTES    = int'(pfd_pkg::PAYLOAD_BYTES);
    localparam int WORD_BYTES   = int'(pfd_pkg::WORD_BYTES);

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME
    } payload_fill_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        overrun;
    logic        out_valid;
    logic        out_ready;
    logic        frame_valid;
    logic [31:0] heading_word;
    logic [31:0] roll_word;
    logic [31:0] pitch_word;
    logic [31:0] pos_x_word;
    logic [31:0] pos_y_word;
    logic [31:0] yaw_rate_word;
    logic        link_up;

    logic        wrap_up;
    int          fail_count;
    int          pending;
    int          frames_published;

    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          overruns_sent = 0;
    bit          calm = 1'b0;

    pose_frame_deframer_core dut (.*);

    pfd_result_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
            $display("[pose_frame_deframer_core] ERROR");
            $finish;
        end
    end

    // receiver side: random stalls, one long hold-off, none in the calm window
    initial
    begin
        int stall_left;
        int rx_cycles;
        stall_left = 0;
        rx_cycles  = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == HOLD_START)
                stall_left = HOLD_CYCLES;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // delimiter values show up often so the parser sees them in every phase
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return pfd_pkg::BYTE_CR;
            1:       return pfd_pkg::BYTE_LF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic ovr);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        overrun  <= ovr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (ovr)
            overruns_sent++;
    endtask

    // header with extra crs, payload, trailer; one position may be spoiled
    task automatic send_frame(input payload_fill_t fill, input int extra_cr,
                              input int break_at, input bit break_ovr);
        logic [7:0] frame_bytes [$];
        logic [7:0] b;
        frame_bytes.push_back(pfd_pkg::BYTE_CR);
        repeat (extra_cr) frame_bytes.push_back(pfd_pkg::BYTE_CR);
        frame_bytes.push_back(pfd_pkg::BYTE_LF);
        for (int i = 0; i < PAY_BYTES; i++)
        begin
            if (fill == FILL_EXTREME)
                frame_bytes.push_back(((i / WORD_BYTES) % 2 == 1) ? 8'hFF : 8'h00);
            else
                frame_bytes.push_back(pick_byte());
        end
        frame_bytes.push_back(pfd_pkg::BYTE_LF);
        frame_bytes.push_back(pfd_pkg::BYTE_CR);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            if (i == break_at && break_ovr)
            begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            else if (i == break_at)
            begin
                do
                    b = pick_byte();
                while (b == frame_bytes[i]);
                send_byte(b, 1'b0);
            end
            else
            begin
                send_byte(frame_bytes[i], 1'b0);
            end
        end
    endtask

    initial
    begin
        int roll;
        int extra;
        int spot;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        overrun  = 1'b0;
        wrap_up  = 1'b0;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // overrun drops a header byte, link stays down
        send_byte(pfd_pkg::BYTE_CR, 1'b1);
        send_byte(pfd_pkg::BYTE_LF, 1'b0);
        // header start raises link, a wrong byte goes back to hunting
        send_byte(pfd_pkg::BYTE_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        // overrun right after a header start clears link
        send_byte(pfd_pkg::BYTE_CR, 1'b0);
        send_byte(8'h00, 1'b1);
        // full frame, repeated crs in the header, all-zero and all-one words
        send_frame(FILL_EXTREME, 2, -1, 1'b0);

        while (bytes_sent < ITEM_TARGET)
        begin
            calm  = (bytes_sent >= CALM_FIRST) && (bytes_sent < CALM_LAST);
            roll  = $urandom_range(99);
            extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
            if (roll < 65)
            begin
                send_frame(FILL_RANDOM, extra, -1, 1'b0);
            end
            else if (roll < 85)
            begin
                if ($urandom_range(1) == 1)
                begin
                    send_frame(FILL_RANDOM, extra,
                               $urandom_range(extra + PAY_BYTES + 3), 1'b1);
                end
                else
                begin
                    case ($urandom_range(3))
                        0:       spot = 0;
                        1:       spot = extra + 1;
                        2:       spot = extra + PAY_BYTES + 2;
                        default: spot = extra + PAY_BYTES + 3;
                    endcase
                    send_frame(FILL_RANDOM, extra, spot, 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    send_byte(pick_byte(), $urandom_range(15) == 0);
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);

        $display("sent %0d bytes (%0d under overrun) as good, broken and noise sequences",
                 bytes_sent, overruns_sent);
        $display("%0d frames published, receiver held off %0d cycles once, %0d mismatches",
                 frames_published, HOLD_CYCLES, fail_count);
        if (fail_count == 0)
            $display("[pose_frame_deframer_core] OK");
        else
            $display("[pose_frame_deframer_core] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_parser.sv
rtl/pfd_payload.sv
rtl/pose_frame_deframer_core.sv
rtl/pfd_checker.sv
bench/pfd_result_checker.sv
bench/pose_frame_deframer_core_tb.sv
